/* src/lis_pkg.sv */
// Shared types and constants for the longest increasing subsequence block.
`timescale 1ns / 1ps

package lis_pkg;

    // Width of the reported length field.
    localparam int LEN_BITS = 11;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_WRITE
    } lis_state_t;

endpackage

/* src/lis_if.sv */
// Valid/ready channel interfaces for request and result items.
`timescale 1ns / 1ps

interface lis_in_if #(parameter int VALUE_BITS = 32);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;
    logic                         first;

    modport source (output valid, output value, output first, input ready);
    modport sink   (input valid, input value, input first, output ready);
endinterface

interface lis_out_if;
    import lis_pkg::*;

    logic                valid;
    logic                ready;
    logic [LEN_BITS-1:0] lis_length;
    logic                overflow;

    modport source (output valid, output lis_length, output overflow, input ready);
    modport sink   (input valid, input lis_length, input overflow, output ready);
endinterface

/* src/longest_increasing_subsequence.sv */
// Streaming LIS length engine: binary search over a tails table held in block RAM.
`timescale 1ns / 1ps

// Channel  Dir  Handshake     Payload
// din      in   valid/ready   value (VALUE_BITS, signed), first
// dout     out  valid/ready   lis_length (11), overflow
// cfg      in   cfg_we        cfg_wdata -> strict_mode
//
// A request is accepted in ST_IDLE, then takes one search step per read on
// the single RAM read port in ST_SEARCH, then writes back in ST_WRITE.
// Reset clears the tail count and the overflow flag and sets strict_mode
// to 1; the RAM is not cleared. A new request is taken while a result waits
// in the output register; write-back holds while that register is still
// full.

module longest_increasing_subsequence #(
    parameter int MAX_TAILS  = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_we,
    input  logic     cfg_wdata,
    lis_in_if.sink   din,
    lis_out_if.source dout
);
    import lis_pkg::*;

    localparam int IDX_W = (MAX_TAILS > 1) ? $clog2(MAX_TAILS) : 1;
    localparam int CNT_W = $clog2(MAX_TAILS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TAILS);

    lis_state_t state_reg, state_next;

    logic                  strict_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  ovf_reg, ovf_next;
    logic [CNT_W-1:0]      lo_reg, lo_next;
    logic [CNT_W-1:0]      hi_reg, hi_next;
    logic [VALUE_BITS-1:0] key_reg;

    logic                  out_valid_reg;
    logic [LEN_BITS-1:0]   out_len_reg;
    logic                  out_ovf_reg;

    logic [VALUE_BITS-1:0] tails_mem [MAX_TAILS];
    logic [VALUE_BITS-1:0] rdata_reg;
    logic                  rd_en;
    logic [CNT_W-1:0]      rd_mid;
    logic                  wr_en;
    logic [CNT_W-1:0]      wr_pos;

    logic                  accept;
    logic                  step_done;
    logic                  go_right;
    logic [CNT_W-1:0]      start_hi;
    logic                  wb_go;
    logic                  append;
    logic [LEN_BITS+CNT_W-1:0] len_wide;

    // midpoint that produced the current read data
    function automatic logic [CNT_W-1:0] rd_mid_cur();
        return lo_reg + ((hi_reg - lo_reg) >> 1);
    endfunction

    assign accept    = din.valid && din.ready;
    assign start_hi  = din.first ? '0 : count_reg;
    // offset-binary keys: unsigned compare matches signed order
    assign go_right  = strict_reg ? (rdata_reg < key_reg) : (rdata_reg <= key_reg);
    assign wb_go     = !out_valid_reg || dout.ready;
    assign append    = (lo_reg >= count_reg);
    assign step_done = !(lo_next < hi_next);

    // Search bounds and read address.
    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                lo_next = '0;
                hi_next = start_hi;
            end
            ST_SEARCH:
            begin
                if (go_right)
                    lo_next = rd_mid_cur() + CNT_W'(1);
                else
                    hi_next = rd_mid_cur();
            end
            ST_WRITE:
            begin
                lo_next = lo_reg;
                hi_next = hi_reg;
            end
            default:
            begin
                lo_next = lo_reg;
                hi_next = hi_reg;
            end
        endcase
        rd_mid = lo_next + ((hi_next - lo_next) >> 1);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = step_done ? ST_WRITE : ST_SEARCH;
            ST_SEARCH:
                if (step_done)
                    state_next = ST_WRITE;
            ST_WRITE:
                if (wb_go)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        din.ready  = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        wr_pos     = lo_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                din.ready = 1'b1;
                rd_en     = accept && !step_done;
                if (accept && din.first)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
            end
            ST_SEARCH:
                rd_en = !step_done;
            ST_WRITE:
                if (wb_go)
                begin
                    if (append)
                    begin
                        wr_pos = count_reg;
                        if (count_reg < MAX_CNT)
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                        else
                            ovf_next = 1'b1;
                    end
                    else
                        wr_en = 1'b1;
                end
            default:
            begin
                din.ready = 1'b0;
            end
        endcase
    end

    assign len_wide = {{LEN_BITS{1'b0}}, count_next};

    // Tails RAM. A write-back in ST_WRITE always lands before the next
    // request's first read from ST_IDLE, so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            tails_mem[wr_pos[IDX_W-1:0]] <= key_reg;
        if (rd_en)
            rdata_reg <= tails_mem[rd_mid[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            key_reg <= {~din.value[VALUE_BITS-1], din.value[VALUE_BITS-2:0]};
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        if (state_reg == ST_WRITE && wb_go)
        begin
            out_len_reg <= len_wide[LEN_BITS-1:0];
            out_ovf_reg <= ovf_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            strict_reg    <= 1'b1;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            if (cfg_we)
                strict_reg <= cfg_wdata;
            if (state_reg == ST_WRITE && wb_go)
                out_valid_reg <= 1'b1;
            else if (dout.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign dout.valid      = out_valid_reg;
    assign dout.lis_length = out_len_reg;
    assign dout.overflow   = out_ovf_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("tail count above table depth");

    a_search_open: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SEARCH |-> lo_reg < hi_reg)
        else $error("search step with empty interval");

    a_wb_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE && out_valid_reg && !dout.ready) |=>
            (state_reg == ST_WRITE && $stable(count_reg)))
        else $error("write-back passed a full output register");

    a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && din.first) |=> (count_reg == '0 && !ovf_reg))
        else $error("first flag did not clear the table");

endmodule
